### rtl/sha1_message_hasher_macros.svh
// assertion macros for the port-level checker file
// no dependencies
`ifndef SHA1_MESSAGE_HASHER_MACROS_SVH
`define SHA1_MESSAGE_HASHER_MACROS_SVH
// implication checked on every rising clock edge, off during reset
`define SMH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/sha1mh_pkg.sv
// package for the sha-1 message hasher: types, constants, round functions
// no dependencies
package sha1mh_pkg;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned LAST_INDEX = 4;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20)      f = (b & c) | (~b & d);
        else if (r < 7'd40) f = b ^ c ^ d;
        else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                f = b ^ c ^ d;
        return f;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)      k = K0;
        else if (r < 7'd40) k = K1;
        else if (r < 7'd60) k = K2;
        else                k = K3;
        return k;
    endfunction
endpackage

### rtl/sha1mh_if.sv
// valid/ready channel interfaces for the sha-1 message hasher
// no dependencies
interface sha1mh_in_if;
    logic valid;
    logic ready;
    logic [7:0] msg_byte;
    logic byte_present;
    logic end_of_message;
    modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1mh_out_if;
    logic valid;
    logic ready;
    logic [31:0] digest_word;
    logic [2:0] word_index;
    logic last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha1_message_hasher.sv
// Streams a message one byte per word and returns its five-word SHA-1 digest.
// Each byte goes into the block buffer in the back end, and every full 64-byte
// block then compresses on the single round unit; closing a message adds padding
// and length, one compression, or two when the padding spills, the second on a
// zeroed block that carries the length, and then the five output words.
// A QUEUE_DEPTH-word queue (four by default) lets the input keep filling while a block compresses.
// depends on sha1mh_pkg, sha1mh_if, sha1mh_front, sha1mh_queue, sha1mh_back
module sha1_message_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1mh_in_if.sink   in_ch,
    sha1mh_out_if.source out_ch
);
    logic full, empty, push, pop;
    sha1mh_pkg::t_in_word qin, qout;

    sha1mh_front u_front (.in_ch(in_ch), .i_full(full), .o_push(push), .o_data(qin));

    sha1mh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(qin), .o_full(full),
        .i_pop(pop), .o_data(qout), .o_empty(empty)
    );

    sha1mh_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_data(qout), .o_pop(pop),
        .out_ch(out_ch)
    );
endmodule

### rtl/sha1mh_queue.sv
// short word queue between the front and the back
// depends on sha1mh_pkg
module sha1mh_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sha1mh_pkg::t_in_word i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output sha1mh_pkg::t_in_word o_data,
    output logic                 o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    sha1mh_pkg::t_in_word r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

### rtl/sha1mh_front.sv
// front: accepts input words, drops empty ones, pushes the rest into the queue
// depends on sha1mh_pkg, sha1mh_if
module sha1mh_front (
    sha1mh_in_if.sink            in_ch,
    input  logic                 i_full,
    output logic                 o_push,
    output sha1mh_pkg::t_in_word o_data
);
    assign in_ch.ready = !i_full;
    // a word with neither byte nor close does nothing
    assign o_push = in_ch.valid && !i_full && (in_ch.byte_present || in_ch.end_of_message);
    assign o_data = '{msg_byte: in_ch.msg_byte, byte_present: in_ch.byte_present,
                      end_of_message: in_ch.end_of_message};
endmodule

### rtl/sha1mh_back.sv
// back: block buffer, message schedule, one sha-1 round per cycle, digest output
// depends on sha1mh_pkg, sha1mh_if
module sha1mh_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  sha1mh_pkg::t_in_word i_data,
    output logic                 o_pop,
    sha1mh_out_if.source         out_ch
);
    typedef enum logic [2:0] {
        S_TAKE, S_PAD, S_ZERO, S_LEN, S_ROUND, S_OUT
    } t_state;

    t_state       r_state;
    logic [31:0]  r_w [16];
    logic [31:0]  r_h [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [63:0]  r_cnt;
    logic [6:0]   r_rnd;
    logic [3:0]   r_wi;
    logic         r_final;   // compression ends the message
    logic         r_more;    // padding spilled, one more zero block follows
    logic         r_pad_after;  // message closes right after this full block
    logic [2:0]   r_oi;
    logic         r_ov;
    logic [31:0]  r_od;

    logic [5:0]  pos;
    logic [3:0]  pwi;
    logic [4:0]  sh;
    logic [31:0] wt, wn, tsum;

    assign pos = r_cnt[5:0];
    assign pwi = pos[5:2];
    assign sh  = {~pos[1:0], 3'b000};
    assign wt  = r_w[0];
    assign wn  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign tsum = {r_a[26:0], r_a[31:27]} + sha1mh_pkg::round_f(r_rnd, r_b, r_c, r_d)
                + r_e + sha1mh_pkg::round_k(r_rnd) + wt;

    assign o_pop = (r_state == S_TAKE) && !i_empty;
    assign out_ch.valid = r_ov;
    assign out_ch.digest_word = r_od;
    assign out_ch.word_index = r_oi;
    assign out_ch.last_word = (r_oi == 3'(sha1mh_pkg::LAST_INDEX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_h <= '{sha1mh_pkg::IV0, sha1mh_pkg::IV1, sha1mh_pkg::IV2,
                     sha1mh_pkg::IV3, sha1mh_pkg::IV4};
            r_cnt <= '0;
            r_rnd <= '0;
            r_wi <= '0;
            r_final <= 1'b0;
            r_more <= 1'b0;
            r_pad_after <= 1'b0;
            r_oi <= '0;
            r_ov <= 1'b0;
        end else begin
            unique case (r_state)
                S_TAKE: begin
                    if (!i_empty) begin
                        if (i_data.byte_present) begin
                            if (pos[1:0] == 2'd0) r_w[pwi] <= {24'd0, i_data.msg_byte} << sh;
                            else r_w[pwi] <= r_w[pwi] | ({24'd0, i_data.msg_byte} << sh);
                            r_cnt <= r_cnt + 64'd1;
                        end
                        if (i_data.byte_present && pos == 6'd63) begin
                            r_state <= S_ROUND;
                            r_final <= 1'b0;
                            r_more <= 1'b0;
                            r_pad_after <= i_data.end_of_message;
                            r_rnd <= '0;
                            {r_a, r_b, r_c, r_d, r_e} <= {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                        end else if (i_data.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (pos[1:0] == 2'd0) r_w[pwi] <= {24'd0, sha1mh_pkg::PAD_BYTE} << sh;
                    else r_w[pwi] <= r_w[pwi] | ({24'd0, sha1mh_pkg::PAD_BYTE} << sh);
                    r_wi <= pwi + 4'd1;
                    r_more <= (pos >= 6'd56);
                    r_state <= (pwi == 4'd15) ? (pos >= 6'd56 ? S_LEN : S_LEN) : S_ZERO;
                end
                S_ZERO: begin
                    // clear the rest of the block one word per cycle
                    r_w[r_wi] <= '0;
                    r_wi <= r_wi + 4'd1;
                    if (r_wi == 4'd15) r_state <= S_LEN;
                end
                S_LEN: begin
                    if (r_more) begin
                        r_final <= 1'b0;
                    end else begin
                        r_w[14] <= r_cnt[60:29];
                        r_w[15] <= {r_cnt[28:0], 3'b000};
                        r_final <= 1'b1;
                    end
                    r_state <= S_ROUND;
                    r_pad_after <= 1'b0;
                    r_rnd <= '0;
                    {r_a, r_b, r_c, r_d, r_e} <= {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                end
                S_ROUND: begin
                    // schedule shifts through the 16-word window
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= {wn[30:0], wn[31]};
                    r_e <= r_d;
                    r_d <= r_c;
                    r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a;
                    r_a <= tsum;
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) begin
                        r_h[0] <= r_h[0] + tsum;
                        r_h[1] <= r_h[1] + r_a;
                        r_h[2] <= r_h[2] + {r_b[1:0], r_b[31:2]};
                        r_h[3] <= r_h[3] + r_c;
                        r_h[4] <= r_h[4] + r_d;
                        if (r_final) begin
                            r_state <= S_OUT;
                            r_oi <= '0;
                        end else if (r_more) begin
                            r_more <= 1'b0;
                            r_wi <= '0;
                            r_state <= S_ZERO;
                        end else if (r_pad_after) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_TAKE;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_od <= r_h[r_oi];
                    end else if (out_ch.ready) begin
                        if (r_oi == 3'(sha1mh_pkg::LAST_INDEX)) begin
                            r_ov <= 1'b0;
                            r_oi <= '0;
                            r_cnt <= '0;
                            r_h <= '{sha1mh_pkg::IV0, sha1mh_pkg::IV1, sha1mh_pkg::IV2,
                                     sha1mh_pkg::IV3, sha1mh_pkg::IV4};
                            r_state <= S_TAKE;
                        end else begin
                            r_oi <= r_oi + 3'd1;
                            r_od <= r_h[r_oi + 3'd1];
                        end
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end
endmodule

### rtl/sha1mh_checker.sv
// port-level checks for the sha-1 message hasher, bound to the top level
// depends on sha1_message_hasher_macros.svh, sha1_message_hasher
`include "sha1_message_hasher_macros.svh"
module sha1mh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_word,
    input logic [2:0]  out_index,
    input logic        out_last
);
    `SMH_ASSERT_IMPL(a_index_range, i_clk, i_rst_n, out_valid, out_index <= 3'd4, "index out of range")
    `SMH_ASSERT_IMPL(a_last_flag, i_clk, i_rst_n, out_valid, out_last == (out_index == 3'd4), "last flag wrong")
    `SMH_ASSERT_NEXT(a_index_step, i_clk, i_rst_n, out_valid && out_ready && !out_last, out_valid && out_index == $past(out_index) + 3'd1, "digest words not in order")
    `SMH_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_word), "stalled word changed")
endmodule

bind sha1_message_hasher sha1mh_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_word(out_ch.digest_word), .out_index(out_ch.word_index), .out_last(out_ch.last_word)
);

### verif/sha1_message_hasher_checker.sv
// checker for the sha-1 message hasher: watches both channels, predicts digests
// depends on sha1mh_pkg and sha1mh_if
`timescale 1ns / 100ps
module sha1_message_hasher_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1mh_in_if        in_ch,
    sha1mh_out_if       out_ch,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_digest_count
);
    logic [31:0] chain [5];
    logic [31:0] blk [16];
    logic [63:0] msg_len;
    sha1mh_pkg::t_out_word digest_q [$];

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) w[r] = blk[r];
        for (int r = 16; r < 80; r++) w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d); k = sha1mh_pkg::K0;
            end else if (r < 40) begin
                f = b ^ c ^ d; k = sha1mh_pkg::K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d); k = sha1mh_pkg::K2;
            end else begin
                f = b ^ c ^ d; k = sha1mh_pkg::K3;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic place_byte(input int pos, input logic [7:0] v);
        int sh;
        sh = (3 - (pos % 4)) * 8;
        if (pos % 4 == 0) blk[pos / 4] = 32'(v) << sh;
        else blk[pos / 4] |= 32'(v) << sh;
    endtask

    task automatic restart();
        chain[0] = sha1mh_pkg::IV0; chain[1] = sha1mh_pkg::IV1; chain[2] = sha1mh_pkg::IV2;
        chain[3] = sha1mh_pkg::IV3; chain[4] = sha1mh_pkg::IV4;
        msg_len = '0;
    endtask

    task automatic absorb(input logic [7:0] v, input logic present, input logic eom);
        int pos;
        logic [63:0] bits;
        sha1mh_pkg::t_out_word o;
        if (present) begin
            pos = int'(msg_len[5:0]);
            place_byte(pos, v);
            msg_len++;
            if (pos == 63) compress();
        end
        if (eom) begin
            pos = int'(msg_len[5:0]);
            place_byte(pos, sha1mh_pkg::PAD_BYTE);
            for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
            if (pos >= 56) begin
                compress();
                for (int i = 0; i < 16; i++) blk[i] = '0;
            end
            bits = msg_len << 3;
            blk[14] = bits[63:32];
            blk[15] = bits[31:0];
            compress();
            for (int i = 0; i < 5; i++) begin
                o.digest_word = chain[i];
                o.word_index = 3'(i);
                o.last_word = (i == sha1mh_pkg::LAST_INDEX);
                digest_q = {digest_q, o};
            end
            restart();
        end
    endtask

    always @(posedge i_clk) begin
        sha1mh_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            restart();
            digest_q.delete();
            o_fail_count <= 0;
            o_digest_count <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                absorb(in_ch.msg_byte, in_ch.byte_present, in_ch.end_of_message);
            if (out_ch.valid && out_ch.ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest word with none expected: %h", out_ch.digest_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (out_ch.digest_word !== exp_w.digest_word ||
                        out_ch.word_index !== exp_w.word_index ||
                        out_ch.last_word !== exp_w.last_word) begin
                        o_fail_count <= o_fail_count + 1;
                        if (out_ch.digest_word !== exp_w.digest_word)
                            $error("digest_word expected %h got %h",
                                   exp_w.digest_word, out_ch.digest_word);
                        if (out_ch.word_index !== exp_w.word_index)
                            $error("word_index expected %0d got %0d",
                                   exp_w.word_index, out_ch.word_index);
                        if (out_ch.last_word !== exp_w.last_word)
                            $error("last_word expected %0d got %0d",
                                   exp_w.last_word, out_ch.last_word);
                    end
                    if (exp_w.last_word) o_digest_count <= o_digest_count + 1;
                end
            end
        end
        o_pending <= digest_q.size();
    end
endmodule

### verif/sha1_message_hasher_test.sv
// stimulus and verdict for the sha-1 message hasher: byte streams under sender idling and receiver stalls
// depends on sha1mh_pkg, sha1mh_if, the hasher and its checker
`timescale 1ns / 100ps
module sha1_message_hasher_test;
    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, digest_count;
    int   send_idle_pct, recv_stall_pct;
    int   hold_cycles;
    int   msg_total;

    sha1mh_in_if  in_ch();
    sha1mh_out_if out_ch();

    sha1_message_hasher i_dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch));

    sha1_message_hasher_checker i_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .o_fail_count(fail_count), .o_pending(pending), .o_digest_count(digest_count)
    );

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input logic [7:0] v, input logic present, input logic eom);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.msg_byte <= v;
        in_ch.byte_present <= present;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (eom) msg_total++;
    endtask

    task automatic send_message(input int len, input int mode);
        logic [7:0] v;
        for (int i = 0; i < len; i++) begin
            v = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : 8'($urandom);
            if (i == len - 1 && $urandom_range(1)) begin
                send_word(v, 1'b1, 1'b1);
                return;
            end
            send_word(v, 1'b1, 1'b0);
            if ($urandom_range(19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
        end
        send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic random_phase(input int idle, input int stall, input int n_items);
        int sent;
        int len;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0: len = $urandom_range(55, 72);
                1: len = $urandom_range(120, 130);
                default: len = $urandom_range(0, 20);
            endcase
            send_message(len, 0);
            sent += len + 1;
        end
    endtask

    initial begin
        #20_000_000;
        $display("sha1_message_hasher_test: errors");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.msg_byte = '0;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        msg_total = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty message, extremes, padding boundaries, no-op word
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_message(1, 1);
        send_message(3, 2);
        send_word(8'hA5, 1'b1, 1'b1);
        send_message(55, 0);
        send_message(56, 1);
        send_message(63, 0);
        send_message(64, 2);

        random_phase(0, 0, 60);
        random_phase(64, 0, 40);
        random_phase(0, 64, 40);
        random_phase(15, 15, 40);

        // long hold-off on the receiver while short messages keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_cycles = 600;
        for (int m = 0; m < 8; m++) send_message($urandom_range(0, 4), 0);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0 || hold_cycles != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("covered %0d messages, %0d digests checked, across idle and stall mixes",
                 msg_total, digest_count);
        if (fail_count == 0)
            $display("sha1_message_hasher_test: clean");
        else
            $display("sha1_message_hasher_test: errors");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/sha1mh_pkg.sv
rtl/sha1mh_if.sv
rtl/sha1mh_queue.sv
rtl/sha1mh_front.sv
rtl/sha1mh_back.sv
rtl/sha1_message_hasher.sv
rtl/sha1mh_checker.sv
verif/sha1_message_hasher_checker.sv
verif/sha1_message_hasher_test.sv
